### src/fslm_pkg.sv
// shared constants, record type and helpers for the fixed string line matcher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fslm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int PAT_IDX_W   = $clog2(PATTERN_MAX);
	localparam int LEN_W       = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic       OP_TEXT      = 1'b0;
	localparam logic       OP_END       = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_PAT0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ICASE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EXACT  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 3'd7;

	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	// one record per closed line, or a counter restart for an empty end of stream
	typedef struct packed {
		logic is_close;
		logic selected;
		logic stream_end;
	} line_rec_t;

	function automatic logic [7:0] fold(input logic [7:0] b, input logic icase);
		if (icase && b >= 8'h41 && b <= 8'h5A) begin
			return b + 8'h20;
		end
		return b;
	endfunction

endpackage

`default_nettype wire

### src/fslm_queue.sv
// short record queue between the front and back halves
// depends on fslm_pkg
`timescale 1ns / 1ps
`default_nettype none

module fslm_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire fslm_pkg::line_rec_t wr_rec,
	output logic                    full,
	input  wire logic               rd_en,
	output fslm_pkg::line_rec_t     rd_rec,
	output logic                    empty
);
	import fslm_pkg::*;

	line_rec_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                do_wr;
	logic                do_rd;

	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/fslm_front.sv
// front half: configuration registers, per-byte shift-and update, line close
// depends on fslm_pkg
`timescale 1ns / 1ps
`default_nettype none

module fslm_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [fslm_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [fslm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                               in_take,
	input  wire logic                               in_op,
	input  wire logic [7:0]                         in_byte,
	output logic                                    rec_push,
	output fslm_pkg::line_rec_t                     rec
);
	import fslm_pkg::*;

	logic [8*PATTERN_MAX-1:0] pattern_q;
	logic [LEN_W-1:0]         pat_len_q;
	logic                     icase_q;
	logic                     exact_q;
	logic                     invert_q;

	logic [PATTERN_MAX-1:0]   prog_q;
	logic                     hit_q;
	logic                     exact_eq_q;
	logic [LEN_W-1:0]         nbytes_q;

	logic [LEN_W-1:0]         len;
	logic [LEN_W-1:0]         len_m1;
	logic [7:0]               fb;
	logic [7:0]               pb [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]   eq;
	logic [PATTERN_MAX-1:0]   prog_nxt;
	logic                     hit_now;
	logic                     exact_fail;
	logic                     is_text;
	logic                     matched;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			pat_len_q <= '0;
			icase_q   <= 1'b0;
			exact_q   <= 1'b0;
			invert_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PAT0:   pattern_q[0*64 +: 64] <= cfg_wdata;
				CFG_PAT1:   pattern_q[1*64 +: 64] <= cfg_wdata;
				CFG_PAT2:   pattern_q[2*64 +: 64] <= cfg_wdata;
				CFG_PAT3:   pattern_q[3*64 +: 64] <= cfg_wdata;
				CFG_LEN:    pat_len_q <= cfg_wdata[LEN_W-1:0];
				CFG_ICASE:  icase_q   <= cfg_wdata[0];
				CFG_EXACT:  exact_q   <= cfg_wdata[0];
				CFG_INVERT: invert_q  <= cfg_wdata[0];
				default:    pattern_q <= pattern_q;
			endcase
		end
	end

	always_comb begin
		len     = (pat_len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_q;
		len_m1  = len - 1'b1;
		fb      = fold(in_byte, icase_q);
		is_text = (in_op == OP_TEXT) && (in_byte != NEWLINE_BYTE);
		for (int i = 0; i < PATTERN_MAX; i++) begin
			pb[i] = fold(pattern_q[8*i +: 8], icase_q);
			eq[i] = (pb[i] == fb) && (LEN_W'(i) < len);
		end
		prog_nxt   = {prog_q[PATTERN_MAX-2:0], 1'b1} & eq;
		hit_now    = (len != '0) && prog_nxt[len_m1[PAT_IDX_W-1:0]];
		exact_fail = (nbytes_q >= LEN_W'(PATTERN_MAX)) ||
			(pb[nbytes_q[PAT_IDX_W-1:0]] != fb);
		if (exact_q) begin
			matched = exact_eq_q && (nbytes_q == len);
		end else begin
			matched = (len == '0) || hit_q;
		end
		rec.is_close   = (in_op == OP_TEXT) || (nbytes_q != '0);
		rec.selected   = matched ^ invert_q;
		rec.stream_end = in_op;
		rec_push       = in_take && !is_text;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q     <= '0;
			hit_q      <= 1'b0;
			exact_eq_q <= 1'b1;
			nbytes_q   <= '0;
		end else if (in_take) begin
			if (is_text) begin
				prog_q <= prog_nxt;
				if (hit_now) begin
					hit_q <= 1'b1;
				end
				if (exact_fail) begin
					exact_eq_q <= 1'b0;
				end
				if (nbytes_q <= LEN_W'(PATTERN_MAX)) begin
					nbytes_q <= nbytes_q + 1'b1;
				end
			end else begin
				prog_q     <= '0;
				hit_q      <= 1'b0;
				exact_eq_q <= 1'b1;
				nbytes_q   <= '0;
			end
		end
	end

endmodule

`default_nettype wire

### src/fslm_back.sv
// back half: line and selection counters, result register
// depends on fslm_pkg
`timescale 1ns / 1ps
`default_nettype none

module fslm_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fslm_pkg::line_rec_t rec,
	input  wire logic                rec_avail,
	output logic                     rec_take,
	input  wire logic                pop,
	output logic                     empty,
	output logic                     line_selected,
	output logic [31:0]              line_number,
	output logic [31:0]              selected_count,
	output logic                     stream_end
);
	import fslm_pkg::*;

	logic [31:0] nl_cnt_q;
	logic [31:0] sel_cnt_q;
	logic        out_valid_q;
	logic [31:0] nl_nxt;
	logic [31:0] sel_nxt;
	logic        out_free;

	assign empty    = !out_valid_q;
	assign out_free = !out_valid_q || pop;
	// a restart record makes no result, so it never waits on the output slot
	assign rec_take = rec_avail && (!rec.is_close || out_free);

	always_comb begin
		nl_nxt  = nl_cnt_q;
		sel_nxt = sel_cnt_q;
		if (!rec.stream_end && nl_cnt_q != SAT32) begin
			nl_nxt = nl_cnt_q + 1'b1;
		end
		if (rec.selected && sel_cnt_q != SAT32) begin
			sel_nxt = sel_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_cnt_q    <= '0;
			sel_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !pop) || (rec_take && rec.is_close);
			if (rec_take) begin
				if (rec.stream_end) begin
					nl_cnt_q  <= '0;
					sel_cnt_q <= '0;
				end else begin
					nl_cnt_q  <= nl_nxt;
					sel_cnt_q <= sel_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take && rec.is_close) begin
			line_selected  <= rec.selected;
			line_number    <= nl_nxt;
			selected_count <= sel_nxt;
			stream_end     <= rec.stream_end;
		end
	end

endmodule

`default_nettype wire

### src/fixed_string_line_matcher.sv
// top level of the fixed string line matcher: front, record queue, back
// depends on fslm_pkg, fslm_front, fslm_queue, fslm_back
//
// Usage:
//   input channel: op and text_byte, taken when push is high and full is low.
//   one byte per cycle while full is low; a newline or an end of stream item closes the line.
//   result channel: line_selected, line_number, selected_count, stream_end
//   are valid while empty is low and are taken when pop is high.
//   configuration: cfg_index selects a register, cfg_data is written when
//   cfg_valid and cfg_ready are high; cfg_ready is always high. write only
//   while the block is idle.
//   throughput: one item per cycle while full is low. each byte updates the
//   shift-and vector in the cycle it is taken; a line close is written to a
//   four deep record queue, and the back half moves it into the result
//   registers once the output register is free or being popped.
//   if the receiver stalls, results wait in the output register and the
//   queue; items keep flowing until the queue holds four records (line closes
//   and stream restarts), then full holds off every item, text bytes too.
//   reset clears the configuration, the line state and both counters; an end
//   of stream also restarts both counters.
`timescale 1ns / 1ps
`default_nettype none

module fixed_string_line_matcher (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic                                op,
	input  wire logic [7:0]                          text_byte,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic                                     line_selected,
	output logic [31:0]                              line_number,
	output logic [31:0]                              selected_count,
	output logic                                     stream_end,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [fslm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fslm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fslm_pkg::*;

	logic      in_take;
	logic      rec_push;
	line_rec_t rec_in;
	line_rec_t rec_out;
	logic      q_empty;
	logic      rec_take;

	assign cfg_ready = 1'b1;
	assign in_take   = push && !full;

	fslm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.in_take   (in_take),
		.in_op     (op),
		.in_byte   (text_byte),
		.rec_push  (rec_push),
		.rec       (rec_in)
	);

	fslm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rec_push),
		.wr_rec (rec_in),
		.full   (full),
		.rd_en  (rec_take),
		.rd_rec (rec_out),
		.empty  (q_empty)
	);

	fslm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec            (rec_out),
		.rec_avail      (!q_empty),
		.rec_take       (rec_take),
		.pop            (pop),
		.empty          (empty),
		.line_selected  (line_selected),
		.line_number    (line_number),
		.selected_count (selected_count),
		.stream_end     (stream_end)
	);

endmodule

`default_nettype wire

### dv/fixed_string_line_matcher_tb.sv
// self-checking testbench for the fixed string line matcher: directed lines, then random
// settings and line streams, each checked against an in-bench line predictor
// depends on fslm_pkg and fixed_string_line_matcher
`timescale 1ns / 1ps
`default_nettype none

import fslm_pkg::*;

typedef struct {
	logic        selected;
	logic [31:0] number;
	logic [31:0] count;
	logic        stream_end;
} line_result_t;

class line_scoreboard;
	logic [63:0]  pat_word [4];
	logic [5:0]   pat_len;
	logic         icase;
	logic         exact;
	logic         invert;
	logic [31:0]  progress;
	bit           hit;
	bit           still_equal;
	int unsigned  line_bytes;
	logic [31:0]  lines_seen;
	logic [31:0]  sel_total;
	line_result_t pending_lines [$];
	int unsigned  errors;
	int unsigned  lines_checked;
	int unsigned  lines_selected;
	int unsigned  stream_ends;

	function new();
		foreach (pat_word[i]) pat_word[i] = '0;
		pat_len = '0;
		icase = 1'b0;
		exact = 1'b0;
		invert = 1'b0;
		lines_seen = '0;
		sel_total = '0;
		errors = 0;
		lines_checked = 0;
		lines_selected = 0;
		stream_ends = 0;
		clear_line();
	endfunction

	function void clear_line();
		progress = '0;
		hit = 1'b0;
		still_equal = 1'b1;
		line_bytes = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		case (idx)
			CFG_PAT0:   pat_word[0] = data;
			CFG_PAT1:   pat_word[1] = data;
			CFG_PAT2:   pat_word[2] = data;
			CFG_PAT3:   pat_word[3] = data;
			CFG_LEN:    pat_len = data[5:0];
			CFG_ICASE:  icase = data[0];
			CFG_EXACT:  exact = data[0];
			CFG_INVERT: invert = data[0];
			default: ;
		endcase
	endfunction

	function logic [7:0] fold_byte(logic [7:0] b);
		if (icase && b >= 8'h41 && b <= 8'h5A) begin
			return b | 8'h20;
		end
		return b;
	endfunction

	function logic [7:0] pat_byte(int unsigned i);
		if (i >= PATTERN_MAX) begin
			return 8'h00;
		end
		return fold_byte(pat_word[i / 8][8 * (i % 8) +: 8]);
	endfunction

	// advance the line state by one request, queue the line result if it closes one
	function void note_request(logic kind, logic [7:0] data_byte);
		int unsigned  used;
		logic [7:0]   fb;
		logic [31:0]  eq;
		logic [32:0]  mask;
		logic         matched;
		line_result_t r;
		used = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
		if (kind == OP_TEXT && data_byte != NEWLINE_BYTE) begin
			fb = fold_byte(data_byte);
			eq = '0;
			for (int i = 0; i < used; i++) begin
				if (pat_byte(i) == fb) eq[i] = 1'b1;
			end
			mask = (33'd1 << used) - 33'd1;
			progress = ((progress << 1) | 32'd1) & eq & mask[31:0];
			if (used > 0 && progress[used - 1]) hit = 1'b1;
			if (line_bytes >= PATTERN_MAX || pat_byte(line_bytes) != fb) still_equal = 1'b0;
			if (line_bytes <= PATTERN_MAX) line_bytes++;
			return;
		end
		// end of stream on an empty line only restarts the counters
		if (kind == OP_END && line_bytes == 0) begin
			clear_line();
			lines_seen = '0;
			sel_total = '0;
			return;
		end
		if (kind == OP_TEXT && lines_seen != SAT32) lines_seen++;
		if (exact) begin
			matched = still_equal && line_bytes == used;
		end else begin
			matched = (used == 0) || hit;
		end
		r.selected = matched ^ invert;
		if (r.selected && sel_total != SAT32) sel_total++;
		r.number = lines_seen;
		r.count = sel_total;
		r.stream_end = kind;
		pending_lines.push_back(r);
		clear_line();
		if (kind == OP_END) begin
			lines_seen = '0;
			sel_total = '0;
		end
	endfunction

	task report_mismatch(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task check_line(logic sel, logic [31:0] num, logic [31:0] cnt, logic se);
		line_result_t e;
		if (pending_lines.size() == 0) begin
			report_mismatch($sformatf("line result with none pending (number %0d)", num));
			return;
		end
		e = pending_lines.pop_front();
		lines_checked++;
		if (sel) lines_selected++;
		if (se) stream_ends++;
		if (sel !== e.selected)
			report_mismatch($sformatf("line %0d selected %b, want %b", e.number, sel, e.selected));
		if (num !== e.number)
			report_mismatch($sformatf("line_number %0d, want %0d", num, e.number));
		if (cnt !== e.count)
			report_mismatch($sformatf("line %0d selected_count %0d, want %0d",
				e.number, cnt, e.count));
		if (se !== e.stream_end)
			report_mismatch($sformatf("line %0d stream_end %b, want %b",
				e.number, se, e.stream_end));
	endtask
endclass

module fixed_string_line_matcher_tb;

	localparam int ITEM_TARGET  = 1650;
	localparam int DRAIN_CYCLES = 10;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push;
	logic                  full;
	logic                  op;
	logic [7:0]            text_byte;
	logic                  empty;
	logic                  pop;
	logic                  line_selected;
	logic [31:0]           line_number;
	logic [31:0]           selected_count;
	logic                  stream_end;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	line_scoreboard sb = new();

	// copy of the current pattern, used to build lines that hit or nearly hit it
	logic [7:0]  pat_text [PATTERN_MAX];
	int unsigned pat_used;
	logic        fold_on;
	bit          tx_idle;
	bit          rx_idle;
	int unsigned items_sent;
	int unsigned settings_used;

	fixed_string_line_matcher i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.op             (op),
		.text_byte      (text_byte),
		.empty          (empty),
		.pop            (pop),
		.line_selected  (line_selected),
		.line_number    (line_number),
		.selected_count (selected_count),
		.stream_end     (stream_end),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send_item(input logic kind, input logic [7:0] data_byte);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		op <= kind;
		text_byte <= data_byte;
		do @(posedge clk); while (full !== 1'b0);
		sb.note_request(kind, data_byte);
		items_sent++;
	endtask

	function automatic logic [7:0] vary_case(input logic [7:0] b);
		logic [7:0] low;
		low = b | 8'h20;
		if (fold_on && low >= 8'h61 && low <= 8'h7A && $urandom_range(0, 1)) begin
			return b ^ 8'h20;
		end
		return b;
	endfunction

	// small alphabet around the case folding edges, plus the byte extremes and an occasional random byte
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 11))
			0:  return 8'h61;
			1:  return 8'h41;
			2:  return 8'h62;
			3:  return 8'h42;
			4:  return 8'h00;
			5:  return 8'hFF;
			6:  return 8'h40;
			7:  return 8'h5B;
			8:  return 8'h5A;
			9:  return 8'h7A;
			10: return 8'h60;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_pattern(input int unsigned from, input int unsigned upto);
		for (int unsigned i = from; i < upto; i++) send_item(OP_TEXT, vary_case(pat_text[i]));
	endtask

	task automatic send_noise(input int unsigned n, input bit full_range);
		repeat (n) begin
			send_item(OP_TEXT, full_range ? 8'($urandom_range(0, 255)) : vary_case(pick_byte()));
		end
	endtask

	task automatic send_line();
		int unsigned kind;
		int unsigned cut;
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			send_pattern(0, pat_used);
		end else if (kind < 45) begin
			send_noise($urandom_range(0, 4), 1'b0);
			send_pattern(0, pat_used);
			send_noise($urandom_range(0, 4), 1'b0);
		end else if (kind < 60) begin
			// near miss: truncated, or one byte flipped
			if (pat_used > 0) begin
				cut = $urandom_range(0, pat_used - 1);
				send_pattern(0, cut);
				if ($urandom_range(0, 1)) begin
					send_item(OP_TEXT, pat_text[cut] ^ (8'd1 << $urandom_range(0, 7)));
					send_pattern(cut + 1, pat_used);
				end
			end else begin
				send_noise($urandom_range(1, 3), 1'b0);
			end
		end else if (kind < 75) begin
			send_noise($urandom_range(0, 10), 1'b0);
		end else if (kind < 85) begin
			send_noise($urandom_range(0, 12), 1'b1);
		end else if (kind < 90) begin
			// empty line
		end else if (kind < 95) begin
			// partial pattern then the full one, overlapping starts
			if (pat_used > 1) send_pattern(0, $urandom_range(1, pat_used - 1));
			send_pattern(0, pat_used);
		end else begin
			send_noise($urandom_range(30, 40), 1'b0);
			if ($urandom_range(0, 1)) send_pattern(0, pat_used);
		end
		if ($urandom_range(0, 99) < 85) begin
			send_item(OP_TEXT, NEWLINE_BYTE);
			if ($urandom_range(0, 19) == 0) send_item(OP_END, 8'($urandom_range(0, 255)));
		end else begin
			send_item(OP_END, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 3) == 0) send_item(OP_END, 8'($urandom_range(0, 255)));
		end
	endtask

	// sender holds off until every line result is back, then lets the record queue settle
	task automatic wait_drained();
		while (sb.pending_lines.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [63:0] p0, input logic [63:0] p1,
		input logic [63:0] p2, input logic [63:0] p3, input logic [63:0] len_word,
		input logic [63:0] icase_word, input logic [63:0] exact_word,
		input logic [63:0] invert_word);
		logic [63:0] words [8];
		words[CFG_PAT0] = p0;
		words[CFG_PAT1] = p1;
		words[CFG_PAT2] = p2;
		words[CFG_PAT3] = p3;
		words[CFG_LEN] = len_word;
		words[CFG_ICASE] = icase_word;
		words[CFG_EXACT] = exact_word;
		words[CFG_INVERT] = invert_word;
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= words[i];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			sb.write_reg(CFG_IDX_W'(i), words[i]);
		end
		cfg_valid <= 1'b0;
		for (int i = 0; i < PATTERN_MAX; i++) pat_text[i] = words[i / 8][8 * (i % 8) +: 8];
		pat_used = (len_word[5:0] > PATTERN_MAX) ? PATTERN_MAX : len_word[5:0];
		fold_on = icase_word[0];
		settings_used++;
	endtask

	task automatic random_setting();
		logic [7:0]  bytes [PATTERN_MAX];
		logic [63:0] w [4];
		logic [63:0] len_word;
		int unsigned style;
		int unsigned r;
		logic [7:0]  fill;
		style = $urandom_range(0, 3);
		fill = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			case (style)
				0: bytes[i] = pick_byte();
				1: bytes[i] = $urandom_range(0, 1) ? 8'h61 : 8'h41;
				2: bytes[i] = fill;
				default: bytes[i] = 8'($urandom_range(0, 255));
			endcase
		end
		for (int i = 0; i < PATTERN_MAX; i++) w[i / 8][8 * (i % 8) +: 8] = bytes[i];
		r = $urandom_range(0, 99);
		len_word = {$urandom(), $urandom()};
		if (r < 10) len_word[5:0] = 6'd0;
		else if (r < 70) len_word[5:0] = 6'($urandom_range(1, 6));
		else if (r < 85) len_word[5:0] = 6'($urandom_range(7, 16));
		else if (r < 95) len_word[5:0] = 6'(PATTERN_MAX);
		else len_word[5:0] = 6'($urandom_range(33, 63));
		set_config(w[0], w[1], w[2], w[3], len_word, {$urandom(), $urandom()},
			{$urandom(), $urandom()}, {$urandom(), $urandom()});
	endtask

	initial begin
		push <= 1'b0;
		op <= OP_TEXT;
		text_byte <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_PAT0;
		cfg_data <= '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		items_sent = 0;
		settings_used = 0;
		pat_used = 0;
		fold_on = 1'b0;
		foreach (pat_text[i]) pat_text[i] = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: empty pattern selects every line
		send_item(OP_TEXT, NEWLINE_BYTE);
		send_item(OP_END, 8'hFF);
		send_item(OP_TEXT, 8'h00);
		send_item(OP_TEXT, 8'hFF);
		send_item(OP_TEXT, NEWLINE_BYTE);
		send_item(OP_TEXT, 8'h41);
		send_item(OP_END, 8'h00);
		push <= 1'b0;
		wait_drained();
		// folded contains with inversion
		set_config(64'h6241, '0, '0, '0, 64'd2, 64'd1, 64'd0, 64'd1);
		send_item(OP_TEXT, 8'h78);
		send_item(OP_TEXT, 8'h61);
		send_item(OP_TEXT, 8'h42);
		send_item(OP_TEXT, NEWLINE_BYTE);
		send_item(OP_TEXT, 8'h71);
		send_item(OP_END, 8'h0A);
		push <= 1'b0;
		wait_drained();
		// exact mode with an empty pattern: only the empty line matches
		set_config('0, '0, '0, '0, 64'd0, 64'd0, 64'd1, 64'd0);
		send_item(OP_TEXT, NEWLINE_BYTE);
		send_item(OP_TEXT, 8'h61);
		send_item(OP_TEXT, NEWLINE_BYTE);

		while (items_sent < ITEM_TARGET) begin
			push <= 1'b0;
			wait_drained();
			random_setting();
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 12)) send_line();
			// leave a line open across the next setting now and then
			if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 4), 1'b0);
		end
		push <= 1'b0;
		wait_drained();

		$display("%0d requests under %0d settings; %0d line results checked",
			items_sent, settings_used, sb.lines_checked);
		$display("%0d lines selected, %0d closed by end of stream",
			sb.lines_selected, sb.stream_ends);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// result side: pop with random stalls
	initial begin
		int unsigned gap;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = rx_idle ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			sb.check_line(line_selected, line_number, selected_count, stream_end);
		end
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
src/fslm_pkg.sv
src/fslm_queue.sv
src/fslm_front.sv
src/fslm_back.sv
src/fixed_string_line_matcher.sv
dv/fixed_string_line_matcher_tb.sv
